// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the translator RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/tpt_pkg.sv =====
// Package for the TLB / page table translator: defaults, widths, command type.
// No dependencies.
package tpt_pkg;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;   // power of two
    localparam int FRAME_COUNT_DEF = 256;
    localparam int OFFSET_BITS_DEF = 8;

    localparam int ADDR_W  = 16;
    localparam int FRAME_W = 8;
    localparam int CNT_W   = 32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture the item, start the page table read
        logic commit;   // resolve the lookup, update state, write the result
    } dp_cmd_t;

endpackage

// ===== rtl/tlb_page_table_translator.sv =====
// Top level of the TLB / page table address translator.
// Sequence: load captures an item and starts the registered page table frame
// RAM read; commit then updates the TLB and writes the result. No new item is
// taken until the previous one commits; commit waits while the output is full and stalled.
// Reset: asynchronous, active low; clears TLB fill, page present bits, the
// free frame pointer and both counters at once, so no clearing pass is needed.
module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = tpt_pkg::PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = tpt_pkg::FRAME_COUNT_DEF,
    parameter int OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input item channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tpt_pkg::ADDR_W-1:0]   logical_address,
    // result item channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tpt_pkg::ADDR_W-1:0]   physical_address,
    output logic [tpt_pkg::FRAME_W-1:0]  frame_id,
    output logic                         tlb_hit,
    output logic                         page_fault,
    output logic [tpt_pkg::CNT_W-1:0]    hit_total,
    output logic [tpt_pkg::CNT_W-1:0]    fault_total
);
    import tpt_pkg::*;

    // load: capture the item and read the frame map RAM at its page.
    // commit: compare against the TLB, pick the frame (TLB, page table or a
    // new frame on fault), reorder the TLB into LRU order and write the result.
    dp_cmd_t cmd;

    // The controller accepts a new item while a finished result is still
    // waiting in the output register; commit holds until that slot drains.
    tpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // The datapath keeps the TLB in registers, oldest entry at index 0;
    // counters saturate and are shown directly as the running totals.
    tpt_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_COUNT  (PAGE_COUNT),
        .FRAME_COUNT (FRAME_COUNT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .logical_address  (logical_address),
        .physical_address (physical_address),
        .frame_id         (frame_id),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .hit_total        (hit_total),
        .fault_total      (fault_total)
    );

endmodule

// ===== rtl/tpt_ctrl.sv =====
// Controller for the translator: handshake and sequencing of load / commit.
// Depends on tpt_pkg and assert_macros.svh.
module tpt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output tpt_pkg::dp_cmd_t cmd
);
    import tpt_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.load       = 1'b0;
        cmd.commit     = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // hold until the result slot is free or drains this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_load_enters_lookup, clk, rst_n, cmd.load, state_reg == ST_LOOKUP, "load did not enter lookup")
    `ASSERT_NEXT(a_one_item_in_flight, clk, rst_n, in_valid && !in_stall, in_stall, "second item accepted during lookup")
    `ASSERT_IMPLIES(a_valid_from_commit, clk, rst_n, $rose(out_valid_reg), $past(cmd.commit), "result shown without commit")

endmodule

// ===== rtl/tpt_datapath.sv =====
// Datapath: LRU TLB registers, page table present bits and frame RAM, counters.
// Depends on tpt_pkg and assert_macros.svh.
module tpt_datapath #(
    parameter int TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = tpt_pkg::PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = tpt_pkg::FRAME_COUNT_DEF,
    parameter int OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tpt_pkg::dp_cmd_t             cmd,
    input  logic [tpt_pkg::ADDR_W-1:0]   logical_address,
    output logic [tpt_pkg::ADDR_W-1:0]   physical_address,
    output logic [tpt_pkg::FRAME_W-1:0]  frame_id,
    output logic                         tlb_hit,
    output logic                         page_fault,
    output logic [tpt_pkg::CNT_W-1:0]    hit_total,
    output logic [tpt_pkg::CNT_W-1:0]    fault_total
);
    import tpt_pkg::*;
    `include "assert_macros.svh"

    localparam int TW     = $clog2(TLB_ENTRIES);
    localparam int FILL_W = $clog2(TLB_ENTRIES + 1);
    localparam int PW     = $clog2(PAGE_COUNT);
    localparam int FW     = $clog2(FRAME_COUNT);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(TLB_ENTRIES);
    localparam logic [FW-1:0]     FRAME_LAST = FW'(FRAME_COUNT - 1);
    localparam logic [ADDR_W-1:0] OFF_MASK   = ADDR_W'((33'd1 << OFFSET_BITS) - 33'd1);
    localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

    logic [ADDR_W-1:0]   addr_reg;
    logic [PW-1:0]       tlb_tag_reg   [TLB_ENTRIES];
    logic [FW-1:0]       tlb_frame_reg [TLB_ENTRIES];
    logic [FILL_W-1:0]   fill_reg;
    logic [PAGE_COUNT-1:0] present_reg;
    logic [FW-1:0]       page_map_mem  [PAGE_COUNT];
    logic [FW-1:0]       map_q_reg;
    logic [FW-1:0]       free_reg;
    logic [CNT_W-1:0]    hit_cnt_reg, fault_cnt_reg;
    logic [ADDR_W-1:0]   phys_reg;
    logic [FRAME_W-1:0]  frame_out_reg;
    logic                hit_reg, fault_reg;

    logic [ADDR_W-1:0]   in_shift, cur_shift, offset;
    logic [PW-1:0]       in_page, page;
    logic [TLB_ENTRIES-1:0] match;
    logic                hit, fault, full;
    logic [TW-1:0]       hit_idx;
    logic [FW-1:0]       new_frame;
    logic [FILL_W-1:0]   shift_lo, dest;

    // page and offset of the incoming and of the held item
    assign in_shift  = logical_address >> OFFSET_BITS;
    assign in_page   = in_shift[PW-1:0];
    assign cur_shift = addr_reg >> OFFSET_BITS;
    assign page      = cur_shift[PW-1:0];
    assign offset    = addr_reg & OFF_MASK;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= logical_address;
        end
    end

    // parallel tag compare over the valid part of the TLB
    for (genvar i = 0; i < TLB_ENTRIES; i++)
    begin : g_match
        assign match[i] = (FILL_W'(i) < fill_reg) && (tlb_tag_reg[i] == page);
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit     = 1'b1;
                hit_idx = TW'(i);
            end
        end
    end

    assign full  = (fill_reg == FILL_FULL);
    assign fault = !hit && !present_reg[page];

    always_comb
    begin
        if (hit)
        begin
            new_frame = tlb_frame_reg[hit_idx];
        end
        else if (present_reg[page])
        begin
            new_frame = map_q_reg;
        end
        else
        begin
            new_frame = free_reg;
        end
    end

    // entries in [shift_lo, dest) move down by one; dest takes the new pair
    always_comb
    begin
        if (hit)
        begin
            shift_lo = FILL_W'(hit_idx);
            dest     = fill_reg - FILL_W'(1);
        end
        else if (full)
        begin
            shift_lo = '0;
            dest     = FILL_FULL - FILL_W'(1);
        end
        else
        begin
            shift_lo = fill_reg;
            dest     = fill_reg;
        end
    end

    for (genvar i = 0; i < TLB_ENTRIES; i++)
    begin : g_entry
        if (i < TLB_ENTRIES - 1)
        begin : g_mid
            always_ff @(posedge clk)
            begin
                if (cmd.commit)
                begin
                    if (FILL_W'(i) == dest)
                    begin
                        tlb_tag_reg[i]   <= page;
                        tlb_frame_reg[i] <= new_frame;
                    end
                    else if (FILL_W'(i) >= shift_lo && FILL_W'(i) < dest)
                    begin
                        tlb_tag_reg[i]   <= tlb_tag_reg[i+1];
                        tlb_frame_reg[i] <= tlb_frame_reg[i+1];
                    end
                end
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (cmd.commit && FILL_W'(i) == dest)
                begin
                    tlb_tag_reg[i]   <= page;
                    tlb_frame_reg[i] <= new_frame;
                end
            end
        end
    end

    // frame map RAM: write on fault, registered read at load
    always_ff @(posedge clk)
    begin
        if (cmd.commit && fault)
        begin
            page_map_mem[page] <= free_reg;
        end
        if (cmd.load)
        begin
            map_q_reg <= page_map_mem[in_page];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            present_reg   <= '0;
            free_reg      <= '0;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (!hit && !full)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            if (hit && hit_cnt_reg != CNT_MAX)
            begin
                hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
            end
            if (fault)
            begin
                present_reg[page] <= 1'b1;
                free_reg          <= (free_reg == FRAME_LAST) ? '0 : free_reg + FW'(1);
                if (fault_cnt_reg != CNT_MAX)
                begin
                    fault_cnt_reg <= fault_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            phys_reg      <= ADDR_W'((32'(new_frame) << OFFSET_BITS) | 32'(offset));
            frame_out_reg <= FRAME_W'(32'(new_frame));
            hit_reg       <= hit;
            fault_reg     <= fault;
        end
    end

    assign physical_address = phys_reg;
    assign frame_id         = frame_out_reg;
    assign tlb_hit          = hit_reg;
    assign page_fault       = fault_reg;
    assign hit_total        = hit_cnt_reg;
    assign fault_total      = fault_cnt_reg;

    `ASSERT_IMPLIES(a_fill_bounded, clk, rst_n, 1'b1, fill_reg <= FILL_FULL, "TLB fill beyond capacity")
    `ASSERT_IMPLIES(a_hit_fault_excl, clk, rst_n, $past(cmd.commit), !(hit_reg && fault_reg), "hit and fault on one item")
    `ASSERT_NEXT(a_fault_sets_present, clk, rst_n, cmd.commit && fault, present_reg[$past(page)], "faulted page not marked present")

endmodule
